// ===== design/seven_segment_scan_keypad_macros.svh =====
// assertion macros for the seven segment scan keypad block
// no dependencies; included by the top level
`ifndef SEVEN_SEGMENT_SCAN_KEYPAD_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_KEYPAD_MACROS_SVH

// same-cycle implication under synchronous reset
`define SSK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define SSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ssk_pkg.sv =====
// shared widths, command codes, controller types and glyph lookup
// no dependencies
`timescale 1ns / 1ps

package ssk_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 3;
  localparam int VAL_W = 16;
  localparam int KEY_W = 4;
  localparam int DRV_W = 4;
  localparam int SEG_W = 3;
  localparam int PH_W  = 5;
  localparam int QUO_W = 13;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POINT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // reciprocal of ten, exact for 16-bit operands with a shift of 19
  localparam logic [16:0] RECIP_TEN = 17'd52429;
  localparam int          RECIP_SH  = 19;

  localparam logic [VAL_W-1:0] LIM_THOUSAND = 16'd1000;
  localparam logic [VAL_W-1:0] LIM_HUNDRED  = 16'd100;
  localparam logic [VAL_W-1:0] LIM_TEN      = 16'd10;

  localparam logic [7:0] POINT_BIT = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SUB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul_en;
    logic sub_en;
    logic fin_en;
  } ctl_t;

  typedef struct packed {
    logic is_dec;
    logic cnt_last;
  } sts_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'h3f;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5b;
      4'h3: g = 8'h4f;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6d;
      4'h6: g = 8'h7d;
      4'h7: g = 8'h27;
      4'h8: g = 8'h7f;
      4'h9: g = 8'h6f;
      4'ha: g = 8'h77;
      4'hb: g = 8'h7c;
      4'hc: g = 8'h58;
      4'hd: g = 8'h5e;
      4'he: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] hex_pattern(input logic [4:0] v);
    logic [7:0] p;
    p = glyph(v[3:0]);
    if (v[4]) p = p | 8'h01;
    return p;
  endfunction

endpackage

// ===== design/ssk_in_if.sv =====
// request channel carrying command, position, value and key levels
// depends on ssk_pkg
`timescale 1ns / 1ps

interface ssk_in_if;
  logic                     valid;
  logic                     ready;
  logic [ssk_pkg::CMD_W-1:0] command;
  logic [ssk_pkg::POS_W-1:0] position;
  logic [ssk_pkg::VAL_W-1:0] value;
  logic [ssk_pkg::KEY_W-1:0] key_levels;

  modport source (output valid, command, position, value, key_levels, input ready);
  modport sink (input valid, command, position, value, key_levels, output ready);
endinterface

// ===== design/ssk_out_if.sv =====
// result channel carrying digit drive, segment line and key nibble
// depends on ssk_pkg
`timescale 1ns / 1ps

interface ssk_out_if;
  logic                     valid;
  logic                     ready;
  logic [ssk_pkg::DRV_W-1:0] digit_drive;
  logic [ssk_pkg::SEG_W-1:0] segment_line;
  logic [ssk_pkg::KEY_W-1:0] key_nibble;

  modport source (output valid, digit_drive, segment_line, key_nibble, input ready);
  modport sink (input valid, digit_drive, segment_line, key_nibble, output ready);
endinterface

// ===== design/ssk_ctrl.sv =====
// controller state machine: request handshake, divide sequencing, result valid
// depends on ssk_pkg
`timescale 1ns / 1ps

module ssk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ssk_pkg::sts_t sts,
  output ssk_pkg::ctl_t ctl
);
  import ssk_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_dec) begin
          state_nxt = ST_MUL;
        end else if (out_free) begin
          ctl.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        ctl.sub_en = 1'b1;
        state_nxt  = sts.cnt_last ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (out_free) begin
          ctl.fin_en    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ssk_dp.sv =====
// datapath: request capture, phase counter, digit patterns, key rows,
// divide-by-ten unit and result registers; depends on ssk_pkg
`timescale 1ns / 1ps

module ssk_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssk_pkg::ctl_t             ctl,
  output ssk_pkg::sts_t             sts,
  input  logic [ssk_pkg::CMD_W-1:0] in_command,
  input  logic [ssk_pkg::POS_W-1:0] in_position,
  input  logic [ssk_pkg::VAL_W-1:0] in_value,
  input  logic [ssk_pkg::KEY_W-1:0] in_key_levels,
  output logic [ssk_pkg::DRV_W-1:0] out_digit_drive,
  output logic [ssk_pkg::SEG_W-1:0] out_segment_line,
  output logic [ssk_pkg::KEY_W-1:0] out_key_nibble
);
  import ssk_pkg::*;

  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [KEY_W-1:0] keys_r;

  logic [PH_W-1:0]  phase_r;
  logic [7:0]       pat_r [4];
  logic [KEY_W-1:0] key_r [8];

  logic [VAL_W-1:0] n_r;
  logic [QUO_W-1:0] q_r;
  logic [1:0]       cnt_r;

  logic [DRV_W-1:0] drv_r;
  logic [SEG_W-1:0] seg_r;
  logic [KEY_W-1:0] nib_r;

  logic [32:0]      prod;
  logic [VAL_W-1:0] q_ten;
  logic [VAL_W-1:0] rem;
  logic [1:0]       digit;
  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] prev_seg;
  logic [1:0]       wr_idx;

  assign sts.is_dec   = (cmd_r == CMD_DEC);
  assign sts.cnt_last = (cnt_r == 2'd3);

  assign digit    = phase_r[1:0];
  assign seg      = phase_r[4:2];
  assign prev_seg = seg - 3'd1;
  assign wr_idx   = 2'd3 - cnt_r;

  assign prod  = {17'd0, n_r} * {16'd0, RECIP_TEN};
  assign q_ten = {q_r[QUO_W-1:0], 3'b000} + {2'b00, q_r[QUO_W-1:0], 1'b0};
  assign rem   = n_r - q_ten;

  assign out_digit_drive  = drv_r;
  assign out_segment_line = seg_r;
  assign out_key_nibble   = nib_r;

  // request capture and divide unit
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= in_command;
      pos_r  <= in_position;
      val_r  <= in_value;
      keys_r <= in_key_levels;
      n_r    <= in_value;
      cnt_r  <= 2'd0;
    end else if (ctl.sub_en) begin
      n_r   <= {3'b000, q_r};
      cnt_r <= cnt_r + 2'd1;
    end
    if (ctl.mul_en) begin
      q_r <= prod[RECIP_SH +: QUO_W];
    end
  end

  // display state and key rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int i = 0; i < 4; i++) pat_r[i] <= '0;
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
    end else begin
      if (ctl.exec) begin
        case (cmd_r)
          CMD_TICK: begin
            if (digit == 2'd0) key_r[prev_seg] <= ~keys_r;
            phase_r <= phase_r + 5'd1;
          end
          CMD_HEX: begin
            pat_r[pos_r[1:0]] <= hex_pattern(val_r[4:0]);
          end
          CMD_POINT: begin
            pat_r[pos_r[1:0]] <= pat_r[pos_r[1:0]] | POINT_BIT;
          end
          default: begin
          end
        endcase
      end
      if (ctl.sub_en) begin
        pat_r[wr_idx] <= hex_pattern({1'b0, rem[3:0]});
      end
      if (ctl.fin_en) begin
        if (val_r < LIM_THOUSAND) pat_r[0] <= '0;
        if (val_r < LIM_HUNDRED) pat_r[1] <= '0;
        if (val_r < LIM_TEN) pat_r[2] <= '0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.fin_en) begin
      drv_r <= '0;
      seg_r <= '0;
      nib_r <= '0;
    end else if (ctl.exec) begin
      drv_r <= '0;
      seg_r <= '0;
      nib_r <= '0;
      case (cmd_r)
        CMD_TICK: begin
          if (pat_r[digit][seg]) drv_r <= 4'b0001 << digit;
          seg_r <= seg;
        end
        CMD_READ: begin
          nib_r <= key_r[pos_r];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/seven_segment_scan_keypad.sv =====
// tick, set and read requests go from idle to execute, which registers the result;
// show decimal goes from execute through four digits of multiply then subtract on
// the divide-by-ten unit to a finish state that registers it. one request in flight:
// none is taken before the last one is done; a waiting result holds the next request
// synchronous active-low reset clears controller state, result valid, phase counter, digit patterns and key rows
`timescale 1ns / 1ps

module seven_segment_scan_keypad (
  input logic clk,
  input logic rst_n,
  ssk_in_if.sink    in_ch,
  ssk_out_if.source out_ch
);
  import ssk_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ssk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ssk_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_position      (in_ch.position),
    .in_value         (in_ch.value),
    .in_key_levels    (in_ch.key_levels),
    .out_digit_drive  (out_ch.digit_drive),
    .out_segment_line (out_ch.segment_line),
    .out_key_nibble   (out_ch.key_nibble)
  );

`include "seven_segment_scan_keypad_macros.svh"

  `SSK_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready,
    "second request taken while busy")
  `SSK_ASSERT_NEXT(a_exec_loads, ctl.exec || ctl.fin_en, out_ch.valid, "result not presented")
  `SSK_ASSERT_NEXT(a_mul_then_sub, ctl.mul_en, ctl.sub_en, "divide step skipped")
  `SSK_ASSERT_SAME(a_key_no_drive, out_ch.valid && (out_ch.key_nibble != 4'd0),
    (out_ch.digit_drive == 4'd0) && (out_ch.segment_line == 3'd0),
    "key result with display fields")

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for the seven segment scan keypad block: scoreboard class with a
// display and key-row predictor, directed then random requests under varied back-pressure
// depends on ssk_pkg, ssk_in_if, ssk_out_if and the seven_segment_scan_keypad top level
`timescale 1ns / 1ps

module tb_top;
  import ssk_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key_levels;
  } request_t;

  typedef struct packed {
    logic [DRV_W-1:0] digit_drive;
    logic [SEG_W-1:0] segment_line;
    logic [KEY_W-1:0] key_nibble;
  } drive_t;

  class display_scan_scoreboard;
    bit [PH_W-1:0]  scan_phase;
    bit [7:0]       pattern [4];
    bit [KEY_W-1:0] key_row [8];
    bit [7:0]       glyph [16];
    drive_t         expected_drives [$];
    int             mismatches;

    function new();
      glyph = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h27,
                8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71};
      scan_phase = '0;
      foreach (pattern[i]) pattern[i] = '0;
      foreach (key_row[i]) key_row[i] = '0;
      mismatches = 0;
    endfunction

    function bit [7:0] hex_glyph(bit [4:0] v);
      return glyph[v[3:0]] | {7'd0, v[4]};
    endfunction

    // advance the display and key state for one accepted request
    function void note_request(request_t r);
      drive_t        e;
      bit [1:0]      dig;
      bit [SEG_W-1:0] seg;
      bit [SEG_W-1:0] prev_row;
      int unsigned   n;
      int            k;
      e = '0;
      case (r.command)
        CMD_TICK: begin
          dig = scan_phase[1:0];
          seg = scan_phase[4:2];
          prev_row = seg - 3'd1;
          if (dig == 2'd0) key_row[prev_row] = ~r.key_levels;
          if (pattern[dig][seg]) e.digit_drive = 4'b0001 << dig;
          e.segment_line = seg;
          scan_phase = scan_phase + 5'd1;
        end
        CMD_HEX: pattern[r.position[1:0]] = hex_glyph(r.value[4:0]);
        CMD_POINT: pattern[r.position[1:0]] = pattern[r.position[1:0]] | POINT_BIT;
        CMD_DEC: begin
          n = 32'(r.value);
          for (k = 3; k >= 0; k--) begin
            pattern[k] = hex_glyph(5'(n % 10));
            n = n / 10;
          end
          if (r.value < LIM_THOUSAND) pattern[0] = '0;
          if (r.value < LIM_HUNDRED) pattern[1] = '0;
          if (r.value < LIM_TEN) pattern[2] = '0;
        end
        CMD_READ: e.key_nibble = key_row[r.position];
        default: ;
      endcase
      expected_drives.push_back(e);
    endfunction

    function void check_result(drive_t got);
      drive_t e;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: drive %h seg %0d keys %h",
                   got.digit_drive, got.segment_line, got.key_nibble);
        return;
      end
      e = expected_drives.pop_front();
      if (got.digit_drive !== e.digit_drive || got.segment_line !== e.segment_line ||
          got.key_nibble !== e.key_nibble) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected drive %h seg %0d keys %h, got drive %h seg %0d keys %h",
                   e.digit_drive, e.segment_line, e.key_nibble,
                   got.digit_drive, got.segment_line, got.key_nibble);
      end
    endfunction

    function int outstanding();
      return expected_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   cycle_count;

  display_scan_scoreboard scan_board = new();

  ssk_in_if  in_ch();
  ssk_out_if out_ch();

  seven_segment_scan_keypad u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side: check accepted results, then pick ready for the next cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        scan_board.check_result('{out_ch.digit_drive, out_ch.segment_line, out_ch.key_nibble});
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic request_t pack_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                            logic [VAL_W-1:0] val, logic [KEY_W-1:0] keys);
    request_t r;
    r.command = cmd;
    r.position = pos;
    r.value = val;
    r.key_levels = keys;
    return r;
  endfunction

  function automatic request_t make_request();
    request_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    r.position = 3'($urandom_range(0, 7));
    r.value = 16'($urandom_range(0, 16'hffff));
    r.key_levels = ($urandom_range(0, 3) == 0) ? 4'hf : 4'($urandom_range(0, 15));
    if (roll < 45) r.command = CMD_TICK;
    else if (roll < 60) r.command = CMD_HEX;
    else if (roll < 66) r.command = CMD_POINT;
    else if (roll < 76) r.command = CMD_DEC;
    else if (roll < 94) r.command = CMD_READ;
    else r.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    if (r.command == CMD_DEC) begin
      case ($urandom_range(0, 4))
        0: r.value = 16'($urandom_range(0, 9));
        1: r.value = 16'($urandom_range(10, 99));
        2: r.value = 16'($urandom_range(100, 999));
        3: r.value = 16'($urandom_range(1000, 9999));
        default: r.value = 16'($urandom_range(0, 16'hffff));
      endcase
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= r.command;
    in_ch.position <= r.position;
    in_ch.value <= r.value;
    in_ch.key_levels <= r.key_levels;
    do @(posedge clk); while (!in_ch.ready);
    scan_board.note_request(r);
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (scan_board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, bit hold_midway);
    int i;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (hold_midway && i == RANDOM_ITEMS / 2) wait_for_drain();
      send_request(make_request());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.position <= '0;
    in_ch.value <= '0;
    in_ch.key_levels <= '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset contents, key extremes, glyph extremes, point, decimal blanking edges, unused commands
    send_request(pack_request(CMD_READ, 3'd0, 16'h0000, 4'hf));
    send_request(pack_request(CMD_READ, 3'd7, 16'hffff, 4'h0));
    send_request(pack_request(CMD_TICK, 3'd7, 16'hffff, 4'h0));
    send_request(pack_request(CMD_TICK, 3'd0, 16'h0000, 4'hf));
    send_request(pack_request(CMD_TICK, 3'd5, 16'h1234, 4'ha));
    send_request(pack_request(CMD_HEX, 3'd0, 16'h0000, 4'h0));
    send_request(pack_request(CMD_HEX, 3'd7, 16'h001f, 4'hf));
    send_request(pack_request(CMD_HEX, 3'd5, 16'hffff, 4'h5));
    send_request(pack_request(CMD_HEX, 3'd2, 16'h0008, 4'h0));
    send_request(pack_request(CMD_POINT, 3'd6, 16'hffff, 4'hf));
    send_request(pack_request(CMD_POINT, 3'd0, 16'h0000, 4'h0));
    send_request(pack_request(CMD_DEC, 3'd0, 16'd0, 4'h0));
    send_request(pack_request(CMD_DEC, 3'd7, 16'd9, 4'hf));
    send_request(pack_request(CMD_DEC, 3'd1, 16'd10, 4'h3));
    send_request(pack_request(CMD_DEC, 3'd2, 16'd99, 4'hc));
    send_request(pack_request(CMD_DEC, 3'd3, 16'd100, 4'h0));
    send_request(pack_request(CMD_DEC, 3'd4, 16'd999, 4'hf));
    send_request(pack_request(CMD_DEC, 3'd5, 16'd1000, 4'h9));
    send_request(pack_request(CMD_DEC, 3'd6, 16'd65535, 4'h6));
    send_request(pack_request(CMD_UNUSED_FIRST, 3'd7, 16'hffff, 4'h0));
    send_request(pack_request(CMD_UNUSED_LAST, 3'd0, 16'h0000, 4'hf));
    send_request(pack_request(CMD_TICK, 3'd0, 16'h0000, 4'h0));
    send_request(pack_request(CMD_READ, 3'd7, 16'h0000, 4'hf));
    send_request(pack_request(CMD_READ, 3'd3, 16'h0000, 4'hf));

    run_phase(20, 68, 1'b1);
    wait_for_drain();
    run_phase(68, 20, 1'b0);
    run_phase(0, 0, 1'b0);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scan_board.mismatches == 0 && scan_board.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ssk_pkg.sv
design/ssk_in_if.sv
design/ssk_out_if.sv
design/ssk_ctrl.sv
design/ssk_dp.sv
design/seven_segment_scan_keypad.sv
test/tb_top.sv
